@@ rtl/core/lmts_pkg.sv @@
// ----------------------------------------------------------------------------
// lmts_pkg
// Shared types, constants and the built-in font of the LED matrix scroller.
// ----------------------------------------------------------------------------
package lmts_pkg;

  localparam int MAX_TEXT      = 64;
  localparam int DEVICES       = 4;
  localparam int GLYPH_COLUMNS = 5;
  localparam int FONT_ENTRIES  = 95;
  localparam int ROWS          = 8;
  localparam int ROW_W         = 8 * DEVICES;
  localparam int FONT_DEPTH    = FONT_ENTRIES * ROWS;
  localparam int FONT_AW       = $clog2(FONT_DEPTH);
  localparam int TEXT_AW       = $clog2(MAX_TEXT);

  // Configuration register indexes.
  localparam logic [1:0] CFG_TEXT_LENGTH   = 2'd0;
  localparam logic [1:0] CFG_SCROLL_ENABLE = 2'd1;
  localparam logic [1:0] CFG_GAP_COLUMNS   = 2'd2;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_TEXT_WRITE = 2'd0,
    OP_RESTART    = 2'd1,
    OP_TICK       = 2'd2,
    OP_FONT_WRITE = 2'd3
  } op_e;

  // Commands passed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_TEXT_WR = 2'd0,
    CMD_FONT_WR = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                 kind;
    logic [TEXT_AW-1:0]   text_index;
    logic [7:0]           char_code;
    logic [FONT_AW-1:0]   font_addr;
    logic [4:0]           glyph_bits;
  } cmd_t;

  typedef struct packed {
    logic [6:0] text_length;
    logic       scroll_enable;
    logic [2:0] gap_columns;
  } cfg_t;

  typedef struct packed {
    logic init_done;
  } back_status_t;

  // Built-in font: one entry per printable code from space to tilde, eight rows.
  localparam logic [4:0] FONT_ROM [FONT_ENTRIES][ROWS] = '{
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    '{5'h04, 5'h00, 5'h00, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00},
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h0A, 5'h0A, 5'h0A, 5'h00},
    '{5'h0A, 5'h0A, 5'h1F, 5'h0A, 5'h1F, 5'h0A, 5'h0A, 5'h00},
    '{5'h04, 5'h0F, 5'h14, 5'h0E, 5'h05, 5'h1E, 5'h04, 5'h00},
    '{5'h18, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h03, 5'h00},
    '{5'h16, 5'h09, 5'h15, 5'h02, 5'h05, 5'h09, 5'h06, 5'h00},
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h02, 5'h04, 5'h06, 5'h00},
    '{5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08, 5'h00},
    '{5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02, 5'h00},
    '{5'h00, 5'h04, 5'h15, 5'h0E, 5'h15, 5'h04, 5'h00, 5'h00},
    '{5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00, 5'h00},
    '{5'h02, 5'h04, 5'h06, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00, 5'h00},
    '{5'h06, 5'h06, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    '{5'h00, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h00, 5'h00},
    '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E, 5'h00},
    '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h06, 5'h04, 5'h00},
    '{5'h1F, 5'h02, 5'h04, 5'h08, 5'h10, 5'h11, 5'h0E, 5'h00},
    '{5'h0E, 5'h11, 5'h10, 5'h08, 5'h04, 5'h08, 5'h1F, 5'h00},
    '{5'h08, 5'h08, 5'h1F, 5'h09, 5'h0A, 5'h0C, 5'h08, 5'h00},
    '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h0F, 5'h01, 5'h1F, 5'h00},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C, 5'h00},
    '{5'h02, 5'h02, 5'h02, 5'h04, 5'h08, 5'h11, 5'h1F, 5'h00},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h00},
    '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E, 5'h00},
    '{5'h06, 5'h06, 5'h00, 5'h06, 5'h06, 5'h00, 5'h00, 5'h00},
    '{5'h02, 5'h04, 5'h06, 5'h00, 5'h06, 5'h06, 5'h00, 5'h00},
    '{5'h08, 5'h04, 5'h02, 5'h01, 5'h02, 5'h04, 5'h08, 5'h00},
    '{5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
    '{5'h02, 5'h04, 5'h08, 5'h10, 5'h08, 5'h04, 5'h02, 5'h00},
    '{5'h04, 5'h00, 5'h04, 5'h08, 5'h10, 5'h11, 5'h0E, 5'h00},
    '{5'h0E, 5'h15, 5'h15, 5'h16, 5'h10, 5'h11, 5'h0E, 5'h00},
    '{5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00},
    '{5'h0F, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h0F, 5'h00},
    '{5'h0E, 5'h11, 5'h01, 5'h01, 5'h01, 5'h11, 5'h0E, 5'h00},
    '{5'h0F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0F, 5'h00},
    '{5'h1F, 5'h01, 5'h01, 5'h1F, 5'h01, 5'h01, 5'h1F, 5'h00},
    '{5'h01, 5'h01, 5'h01, 5'h0F, 5'h01, 5'h01, 5'h1F, 5'h00},
    '{5'h0E, 5'h11, 5'h11, 5'h1D, 5'h01, 5'h11, 5'h0E, 5'h00},
    '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11, 5'h00},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F, 5'h00},
    '{5'h06, 5'h09, 5'h09, 5'h08, 5'h08, 5'h08, 5'h1E, 5'h00},
    '{5'h11, 5'h09, 5'h05, 5'h03, 5'h05, 5'h09, 5'h11, 5'h00},
    '{5'h1F, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h00},
    '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11, 5'h00},
    '{5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h00},
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00},
    '{5'h01, 5'h01, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h0F, 5'h00},
    '{5'h16, 5'h09, 5'h15, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00},
    '{5'h11, 5'h11, 5'h09, 5'h0F, 5'h11, 5'h11, 5'h0F, 5'h00},
    '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E, 5'h00},
    '{5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F, 5'h00},
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h00},
    '{5'h04, 5'h0A, 5'h0A, 5'h11, 5'h11, 5'h11, 5'h11, 5'h00},
    '{5'h0A, 5'h15, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11, 5'h00},
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11, 5'h00},
    '{5'h04, 5'h04, 5'h04, 5'h04, 5'h0A, 5'h11, 5'h11, 5'h00},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F, 5'h00},
    '{5'h07, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h07, 5'h00},
    '{5'h00, 5'h10, 5'h08, 5'h04, 5'h02, 5'h01, 5'h00, 5'h00},
    '{5'h1C, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1C, 5'h00},
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h11, 5'h0A, 5'h04, 5'h00},
    '{5'h1F, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h08, 5'h04, 5'h02, 5'h00},
    '{5'h1E, 5'h11, 5'h1E, 5'h10, 5'h0E, 5'h00, 5'h00, 5'h00},
    '{5'h0F, 5'h11, 5'h11, 5'h13, 5'h0D, 5'h01, 5'h01, 5'h00},
    '{5'h0E, 5'h11, 5'h01, 5'h01, 5'h0E, 5'h00, 5'h00, 5'h00},
    '{5'h1E, 5'h11, 5'h11, 5'h19, 5'h16, 5'h10, 5'h10, 5'h00},
    '{5'h0E, 5'h01, 5'h1F, 5'h11, 5'h0E, 5'h00, 5'h00, 5'h00},
    '{5'h02, 5'h02, 5'h02, 5'h07, 5'h02, 5'h12, 5'h0C, 5'h00},
    '{5'h0E, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h00, 5'h00},
    '{5'h11, 5'h11, 5'h11, 5'h13, 5'h0D, 5'h01, 5'h01, 5'h00},
    '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h06, 5'h00, 5'h04, 5'h00},
    '{5'h06, 5'h09, 5'h08, 5'h08, 5'h0C, 5'h00, 5'h08, 5'h00},
    '{5'h09, 5'h05, 5'h03, 5'h05, 5'h09, 5'h01, 5'h01, 5'h00},
    '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h06, 5'h00},
    '{5'h11, 5'h11, 5'h15, 5'h15, 5'h0A, 5'h00, 5'h00, 5'h00},
    '{5'h11, 5'h11, 5'h11, 5'h13, 5'h0D, 5'h00, 5'h00, 5'h00},
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E, 5'h00, 5'h00, 5'h00},
    '{5'h01, 5'h01, 5'h0F, 5'h11, 5'h0F, 5'h00, 5'h00, 5'h00},
    '{5'h08, 5'h08, 5'h0E, 5'h09, 5'h0E, 5'h00, 5'h00, 5'h00},
    '{5'h01, 5'h01, 5'h01, 5'h13, 5'h0D, 5'h00, 5'h00, 5'h00},
    '{5'h0F, 5'h10, 5'h0E, 5'h01, 5'h0E, 5'h00, 5'h00, 5'h00},
    '{5'h0C, 5'h12, 5'h02, 5'h02, 5'h07, 5'h02, 5'h02, 5'h00},
    '{5'h16, 5'h19, 5'h11, 5'h11, 5'h11, 5'h00, 5'h00, 5'h00},
    '{5'h04, 5'h0A, 5'h11, 5'h11, 5'h11, 5'h00, 5'h00, 5'h00},
    '{5'h0A, 5'h15, 5'h15, 5'h11, 5'h11, 5'h00, 5'h00, 5'h00},
    '{5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h00, 5'h00, 5'h00},
    '{5'h0E, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h00, 5'h00, 5'h00},
    '{5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F, 5'h00, 5'h00, 5'h00},
    '{5'h08, 5'h04, 5'h04, 5'h02, 5'h04, 5'h04, 5'h08, 5'h00},
    '{5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00},
    '{5'h02, 5'h04, 5'h04, 5'h08, 5'h04, 5'h04, 5'h02, 5'h00},
    '{5'h00, 5'h00, 5'h00, 5'h09, 5'h16, 5'h00, 5'h00, 5'h00}
  };

endpackage

@@ rtl/core/lmts_if.sv @@
// ----------------------------------------------------------------------------
// lmts_if
// Valid/ready channels carrying scroller commands in and frame rows out.
// ----------------------------------------------------------------------------
interface lmts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [5:0] text_index;
  logic [7:0] char_code;
  logic [6:0] glyph_index;
  logic [2:0] glyph_row;
  logic [4:0] glyph_bits;

  modport source (
    output valid, operation, text_index, char_code, glyph_index, glyph_row, glyph_bits,
    input  ready
  );
  modport sink (
    input  valid, operation, text_index, char_code, glyph_index, glyph_row, glyph_bits,
    output ready
  );
endinterface

interface lmts_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  row_number;
  logic [31:0] row_bits;
  logic        last_row;

  modport source (
    output valid, row_number, row_bits, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_number, row_bits, last_row,
    output ready
  );
endinterface

@@ rtl/core/lmts_front.sv @@
// ----------------------------------------------------------------------------
// lmts_front
// Accepts input transactions, drops the ones with no effect and classifies
// the rest into commands for the queue.
// ----------------------------------------------------------------------------
module lmts_front import lmts_pkg::*; (
  lmts_in_if.sink     in_i,
  input  cfg_t         cfg_i,
  input  back_status_t status_i,
  input  logic         q_full_i,
  output logic         push_o,
  output cmd_t         push_cmd_o
);

  logic keep;
  logic len_zero;

  assign in_i.ready = status_i.init_done && !q_full_i;
  assign len_zero   = (cfg_i.text_length == 7'd0);

  always_comb begin
    keep                  = 1'b1;
    push_cmd_o.kind       = CMD_TEXT_WR;
    push_cmd_o.text_index = in_i.text_index;
    push_cmd_o.char_code  = in_i.char_code;
    push_cmd_o.font_addr  = {in_i.glyph_index, in_i.glyph_row};
    push_cmd_o.glyph_bits = in_i.glyph_bits;
    case (op_e'(in_i.operation))
      OP_TEXT_WRITE: begin
        push_cmd_o.kind = CMD_TEXT_WR;
      end
      OP_RESTART: begin
        push_cmd_o.kind = CMD_RESTART;
      end
      OP_TICK: begin
        // A paused tick or one with no text leaves everything untouched.
        push_cmd_o.kind = CMD_TICK;
        keep            = cfg_i.scroll_enable && !len_zero;
      end
      OP_FONT_WRITE: begin
        push_cmd_o.kind = CMD_FONT_WR;
        keep            = ({1'b0, in_i.glyph_index} < 8'(FONT_ENTRIES));
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = in_i.valid && in_i.ready && keep;

endmodule

@@ rtl/core/lmts_queue.sv @@
// ----------------------------------------------------------------------------
// lmts_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lmts_queue import lmts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/core/lmts_back.sv @@
// ----------------------------------------------------------------------------
// lmts_back
// Executes queued commands: owns the text and font memories, the frame rows
// and the scroll counters, and streams eight rows per restart or tick.
// ----------------------------------------------------------------------------
module lmts_back import lmts_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         q_valid_i,
  input  cmd_t         q_cmd_i,
  output logic         pop_o,
  output back_status_t status_o,
  lmts_out_if.source   out_o
);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_ROWS
  } state_e;

  typedef enum logic [1:0] {
    PH_GLYPH,
    PH_SPACE,
    PH_PAD
  } phase_e;

  typedef enum logic [1:0] {
    ROW_CLEAR,
    ROW_GLYPH,
    ROW_BLANK
  } row_mode_e;

  state_e              state_q;
  logic [FONT_AW-1:0]  init_cnt_q;
  logic [2:0]          row_q;
  row_mode_e           mode_q;
  logic [2:0]          tick_col_q;
  logic                text_hi_q;

  phase_e              phase_q, phase_d;
  logic [6:0]          pos_q, pos_d;
  logic [2:0]          col_q, col_d;
  logic [2:0]          spc_q, spc_d;
  logic [3:0]          pad_q, pad_d;

  logic [ROW_W-1:0]    frame_q [ROWS];

  logic                s2_valid_q;
  logic [2:0]          s2_row_q;
  row_mode_e           s2_mode_q;
  logic [2:0]          s2_col_q;

  logic                out_valid_q;
  logic [3:0]          out_row_q;
  logic [ROW_W-1:0]    out_bits_q;
  logic                out_last_q;

  logic [7:0]          text_mem [MAX_TEXT];
  logic [7:0]          text_rd_q;
  logic [4:0]          font_mem [FONT_DEPTH];
  logic [4:0]          font_rd_q;

  logic                pop;
  logic                is_tick;
  logic                issue;
  logic                s2_adv;
  logic                font_we;
  logic [FONT_AW-1:0]  font_wa;
  logic [4:0]          font_wd;
  logic [6:0]          entry;
  logic [6:0]          len_eff;
  logic [2:0]          space;
  logic [ROW_W-1:0]    cur_row;
  logic [ROW_W-1:0]    new_row;
  logic                glyph_bit;

  assign pop      = (state_q == ST_IDLE) && q_valid_i;
  assign pop_o    = pop;
  assign is_tick  = pop && (q_cmd_i.kind == CMD_TICK);
  assign s2_adv   = s2_valid_q && (!out_valid_q || out_o.ready);
  assign issue    = (state_q == ST_ROWS) && (!s2_valid_q || s2_adv);

  assign status_o.init_done = (state_q != ST_INIT);

  assign len_eff = (cfg_i.text_length > 7'(MAX_TEXT)) ? 7'(MAX_TEXT) : cfg_i.text_length;
  assign space   = (cfg_i.gap_columns == 3'd0) ? 3'd1 : cfg_i.gap_columns;

  // Font entry of the character fetched for the running tick.
  always_comb begin
    entry = 7'd0;
    if (!text_hi_q && (text_rd_q inside {[8'd32:8'd126]})) begin
      entry = 7'(text_rd_q - 8'd32);
    end
    if ({1'b0, entry} >= 8'(FONT_ENTRIES)) begin
      entry = 7'd0;
    end
  end

  // Font memory write: the start-up fill, or a font row command.
  always_comb begin
    font_we = 1'b0;
    font_wa = q_cmd_i.font_addr;
    font_wd = q_cmd_i.glyph_bits;
    if (state_q == ST_INIT) begin
      font_we = 1'b1;
      font_wa = init_cnt_q;
      font_wd = FONT_ROM[init_cnt_q[FONT_AW-1:3]][init_cnt_q[2:0]];
    end else if (pop && (q_cmd_i.kind == CMD_FONT_WR)) begin
      font_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (font_we) begin
      font_mem[font_wa] <= font_wd;
    end
    if (issue) begin
      font_rd_q <= font_mem[FONT_AW'({entry, row_q})];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && (q_cmd_i.kind == CMD_TEXT_WR)) begin
      text_mem[q_cmd_i.text_index] <= q_cmd_i.char_code;
    end
    if (is_tick) begin
      text_rd_q <= text_mem[pos_q[TEXT_AW-1:0]];
    end
  end

  // Scroll counters advance once per tick, when the tick is dequeued.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    col_d   = col_q;
    spc_d   = spc_q;
    pad_d   = pad_q;
    case (phase_q)
      PH_GLYPH: begin
        col_d = col_q + 3'd1;
        if (col_d >= 3'(GLYPH_COLUMNS)) begin
          col_d   = 3'd0;
          spc_d   = 3'd0;
          phase_d = PH_SPACE;
        end
      end
      PH_SPACE: begin
        spc_d = spc_q + 3'd1;
        if (spc_d >= space) begin
          spc_d = 3'd0;
          pos_d = pos_q + 7'd1;
          if (pos_d >= len_eff) begin
            phase_d = PH_PAD;
            pad_d   = 4'd0;
          end else begin
            phase_d = PH_GLYPH;
          end
        end
      end
      default: begin
        pad_d = pad_q + 4'd1;
        if (pad_d >= 4'(GLYPH_COLUMNS) + {1'b0, space}) begin
          pos_d   = 7'd0;
          col_d   = 3'd0;
          spc_d   = 3'd0;
          pad_d   = 4'd0;
          phase_d = PH_GLYPH;
        end
      end
    endcase
  end

  // Row update for the row waiting in the second stage.
  always_comb begin
    cur_row   = frame_q[s2_row_q];
    glyph_bit = (s2_col_q < 3'(GLYPH_COLUMNS)) ? font_rd_q[s2_col_q] : 1'b0;
    case (s2_mode_q)
      ROW_CLEAR: new_row = '0;
      ROW_GLYPH: new_row = {glyph_bit, cur_row[ROW_W-1:1]};
      default:   new_row = {1'b0, cur_row[ROW_W-1:1]};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_cnt_q  <= '0;
      row_q       <= 3'd0;
      mode_q      <= ROW_CLEAR;
      tick_col_q  <= 3'd0;
      text_hi_q   <= 1'b0;
      phase_q     <= PH_GLYPH;
      pos_q       <= 7'd0;
      col_q       <= 3'd0;
      spc_q       <= 3'd0;
      pad_q       <= 4'd0;
      for (int r = 0; r < ROWS; r++) begin
        frame_q[r] <= '0;
      end
      s2_valid_q  <= 1'b0;
      s2_row_q    <= 3'd0;
      s2_mode_q   <= ROW_CLEAR;
      s2_col_q    <= 3'd0;
      out_valid_q <= 1'b0;
      out_row_q   <= 4'd1;
      out_bits_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_INIT: begin
          init_cnt_q <= init_cnt_q + FONT_AW'(1);
          if (init_cnt_q == FONT_AW'(FONT_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop && (q_cmd_i.kind == CMD_RESTART)) begin
            mode_q  <= ROW_CLEAR;
            row_q   <= 3'd0;
            phase_q <= PH_GLYPH;
            pos_q   <= 7'd0;
            col_q   <= 3'd0;
            spc_q   <= 3'd0;
            pad_q   <= 4'd0;
            state_q <= ST_ROWS;
          end else if (is_tick) begin
            mode_q     <= (phase_q == PH_GLYPH) ? ROW_GLYPH : ROW_BLANK;
            tick_col_q <= col_q;
            text_hi_q  <= pos_q[6];
            row_q      <= 3'd0;
            phase_q    <= phase_d;
            pos_q      <= pos_d;
            col_q      <= col_d;
            spc_q      <= spc_d;
            pad_q      <= pad_d;
            state_q    <= ST_ROWS;
          end
        end
        ST_ROWS: begin
          if (issue) begin
            row_q <= row_q + 3'd1;
            if (row_q == 3'(ROWS - 1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // Second stage: font row data is in font_rd_q.
      if (issue) begin
        s2_valid_q <= 1'b1;
        s2_row_q   <= row_q;
        s2_mode_q  <= mode_q;
        s2_col_q   <= tick_col_q;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end

      if (s2_adv) begin
        frame_q[s2_row_q] <= new_row;
        out_valid_q       <= 1'b1;
        out_row_q         <= {1'b0, s2_row_q} + 4'd1;
        out_bits_q        <= new_row;
        out_last_q        <= (s2_row_q == 3'(ROWS - 1));
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.row_number = out_row_q;
  assign out_o.row_bits   = out_bits_q;
  assign out_o.last_row   = out_last_q;

endmodule

@@ rtl/core/led_matrix_text_scroller.sv @@
// ----------------------------------------------------------------------------
// led_matrix_text_scroller
// Text scroller for eight rows of four cascaded 8x8 LED modules.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake     Carries
//   in_i      sink       valid/ready   operation, text and font fields
//   out_o     source     valid/ready   row_number, row_bits, last_row
//   cfg       write      cfg_we_i      text_length, scroll_enable, gap_columns
//
// After reset the font memory is filled from the built-in table, one row per
// cycle; in_i.ready stays low during that fill. A restart or an enabled tick
// is dequeued (a tick fetching its character), then the back end issues one font
// memory read per frame row. A two-entry queue and the output register
// let the input side keep taking transactions while rows wait on out_o.ready.
//
// The front end classifies each input transaction: paused ticks, ticks with no
// text and font writes beyond the font are dropped on the spot. Everything else
// goes through the queue in order, so memory writes and scrolling never race.
module led_matrix_text_scroller import lmts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lmts_in_if.sink    in_i,
  lmts_out_if.source out_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_wdata_i
);

  cfg_t         cfg_q;
  back_status_t status;
  logic         push;
  cmd_t         push_cmd;
  logic         q_full;
  logic         q_valid;
  cmd_t         q_cmd;
  logic         pop;

  // Configuration registers; writes to unused indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_length   <= 7'd0;
      cfg_q.scroll_enable <= 1'b0;
      cfg_q.gap_columns   <= 3'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TEXT_LENGTH:   cfg_q.text_length   <= cfg_wdata_i;
        CFG_SCROLL_ENABLE: cfg_q.scroll_enable <= cfg_wdata_i[0];
        CFG_GAP_COLUMNS:   cfg_q.gap_columns   <= cfg_wdata_i[2:0];
        default: begin
        end
      endcase
    end
  end

  // The front end only decides whether a transaction matters and what it is.
  lmts_front u_front (
    .in_i       (in_i),
    .cfg_i      (cfg_q),
    .status_i   (status),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  lmts_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd)
  );

  // The back end owns the text, font and frame state and produces the frame rows.
  lmts_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .pop_o     (pop),
    .status_o  (status),
    .out_o     (out_o)
  );

endmodule

@@ dv/tb_led_matrix_text_scroller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_matrix_text_scroller
// Self-checking bench for the LED matrix text scroller. Commands are sent on
// the input channel with random gaps, and rows are taken with random stalls.
// Every frame row that comes back is checked against a shadow copy of the
// frame, the text and font stores and the scroll counters kept in the bench.
// ----------------------------------------------------------------------------
module tb_led_matrix_text_scroller;
  import lmts_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 10;
  // A transaction that yields no rows may still sit in the two-entry queue when
  // the last row arrives, so this is a generous settling time before any
  // register write.
  localparam int SETTLE_CYCLES = 32;
  // The longest quiet stretch in a good run is the font fill after reset.
  // Everything else is far shorter.
  localparam int STALL_LIMIT   = 4000;

  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] TILDE_CODE = 8'h7E;

  // Where the bench's copy of the scroller is within one pass over the text.
  typedef enum logic [1:0] {
    SEG_GLYPH,
    SEG_GAP,
    SEG_TAIL
  } scroll_seg_e;

  typedef struct {
    op_e        op;
    logic [5:0] text_index;
    logic [7:0] char_code;
    logic [6:0] glyph_index;
    logic [2:0] glyph_row;
    logic [4:0] glyph_bits;
  } scroll_cmd_t;

  typedef struct {
    logic [3:0]  row_number;
    logic [31:0] row_bits;
    logic        last_row;
  } frame_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_wdata;

  lmts_in_if  in_if ();
  lmts_out_if out_if ();

  led_matrix_text_scroller DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Shadow state of the scroller. It is updated at the clock edge where a
  // transaction is accepted, in the order in which transactions are accepted.
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0] shadow_frame [ROWS];
  logic [7:0]       shadow_text  [MAX_TEXT];
  logic [4:0]       shadow_font  [FONT_ENTRIES][ROWS];
  bit               text_written [MAX_TEXT];
  int               text_fill;     // entries 0 .. text_fill-1 are all written
  scroll_seg_e      seg;
  int               char_pos;
  int               col_cnt;
  int               gap_cnt;
  int               tail_cnt;

  // Register values as last written.
  logic [6:0] cur_len;
  logic       cur_enable;
  logic [2:0] cur_spacing;

  // Rows that the block still owes us, oldest first.
  frame_row_t pending_rows [$];
  frame_row_t head_row;

  int fail_count;
  bit idle_on;       // random gaps and stalls on both channels
  int rx_hold;       // cycles the output side still holds ready low
  int quiet_cycles;

  always #HALF_PERIOD clk = ~clk;

  // Shift one new column into the left edge of every row; bit r goes to row r.
  function automatic void shift_column(input logic [ROWS-1:0] col_bits);
    for (int r = 0; r < ROWS; r++) begin
      shadow_frame[r] = {col_bits[r], shadow_frame[r][ROW_W-1:1]};
    end
  endfunction

  // A restart or an enabled tick reports the whole frame, rows 1 to 8.
  function automatic void queue_frame();
    frame_row_t fr;
    for (int r = 0; r < ROWS; r++) begin
      fr.row_number = 4'(r + 1);
      fr.row_bits   = shadow_frame[r];
      fr.last_row   = (r == ROWS - 1);
      pending_rows.push_back(fr);
    end
  endfunction

  // Apply one accepted transaction to the shadow state and queue its rows.
  function automatic void apply_cmd(input scroll_cmd_t c);
    int              len;
    int              gap_cols;
    int              code;
    int              entry;
    logic [ROWS-1:0] col_bits;
    // Lengths past the text store act as a full store; zero spacing acts as one.
    len      = (cur_len > MAX_TEXT) ? MAX_TEXT : int'(cur_len);
    gap_cols = (cur_spacing == 0) ? 1 : int'(cur_spacing);
    case (c.op)
      OP_TEXT_WRITE: begin
        shadow_text[c.text_index]  = c.char_code;
        text_written[c.text_index] = 1'b1;
        while (text_fill < MAX_TEXT && text_written[text_fill]) text_fill++;
      end
      OP_FONT_WRITE: begin
        // Writes past the last font entry are dropped by the block.
        if (c.glyph_index < FONT_ENTRIES) begin
          shadow_font[c.glyph_index][c.glyph_row] = c.glyph_bits;
        end
      end
      OP_RESTART: begin
        for (int r = 0; r < ROWS; r++) shadow_frame[r] = '0;
        seg      = SEG_GLYPH;
        char_pos = 0;
        col_cnt  = 0;
        gap_cnt  = 0;
        tail_cnt = 0;
        queue_frame();
      end
      OP_TICK: begin
        // A paused tick or one with no text does nothing at all.
        if (cur_enable && len != 0) begin
          case (seg)
            SEG_GLYPH: begin
              code = (char_pos < MAX_TEXT) ? int'(shadow_text[char_pos]) : int'(SPACE_CODE);
              // Codes outside the printable range are drawn with the space glyph.
              entry = (code < SPACE_CODE || code > TILDE_CODE) ? 0 : code - SPACE_CODE;
              for (int r = 0; r < ROWS; r++) col_bits[r] = shadow_font[entry][r][col_cnt];
              shift_column(col_bits);
              col_cnt++;
              if (col_cnt >= GLYPH_COLUMNS) begin
                col_cnt = 0;
                gap_cnt = 0;
                seg     = SEG_GAP;
              end
            end
            SEG_GAP: begin
              shift_column('0);
              gap_cnt++;
              if (gap_cnt >= gap_cols) begin
                gap_cnt = 0;
                char_pos++;
                if (char_pos >= len) begin
                  seg      = SEG_TAIL;
                  tail_cnt = 0;
                end else begin
                  seg = SEG_GLYPH;
                end
              end
            end
            default: begin
              // Blank tail after the last character, then back to the start.
              shift_column('0);
              tail_cnt++;
              if (tail_cnt >= GLYPH_COLUMNS + gap_cols) begin
                char_pos = 0;
                col_cnt  = 0;
                gap_cnt  = 0;
                tail_cnt = 0;
                seg      = SEG_GLYPH;
              end
            end
          endcase
          queue_frame();
        end
      end
      default: ;
    endcase
  endfunction

  // A command with every field random; the tests override what they need.
  function automatic scroll_cmd_t random_cmd();
    scroll_cmd_t c;
    int          pick;
    c.text_index = 6'($urandom);
    c.char_code  = 8'($urandom);
    // Mostly real font entries, now and then any 7-bit index, which may lie past the end of the font.
    c.glyph_index = ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                                : 7'($urandom_range(0, FONT_ENTRIES - 1));
    c.glyph_row  = 3'($urandom);
    c.glyph_bits = 5'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      c.op = OP_TICK;
    end else if (pick < 82) begin
      c.op = OP_TEXT_WRITE;
    end else if (pick < 92) begin
      c.op = OP_FONT_WRITE;
    end else begin
      c.op = OP_RESTART;
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Every task here starts and ends at a falling edge, so valid is
  // only raised or lowered once per time step: with no gap it simply stays high
  // into the next transaction.
  // --------------------------------------------------------------------------
  task automatic send_cmd(input scroll_cmd_t c);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= c.op;
    in_if.text_index  <= c.text_index;
    in_if.char_code   <= c.char_code;
    in_if.glyph_index <= c.glyph_index;
    in_if.glyph_row   <= c.glyph_row;
    in_if.glyph_bits  <= c.glyph_bits;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    apply_cmd(c);
    @(negedge clk);
  endtask

  task automatic put_text(input int idx, input logic [7:0] code);
    scroll_cmd_t c;
    c            = random_cmd();
    c.op         = OP_TEXT_WRITE;
    c.text_index = 6'(idx);
    c.char_code  = code;
    send_cmd(c);
  endtask

  task automatic put_font(input int glyph, input int row, input logic [4:0] bits);
    scroll_cmd_t c;
    c             = random_cmd();
    c.op          = OP_FONT_WRITE;
    c.glyph_index = 7'(glyph);
    c.glyph_row   = 3'(row);
    c.glyph_bits  = bits;
    send_cmd(c);
  endtask

  task automatic put_op(input op_e op);
    scroll_cmd_t c;
    c    = random_cmd();
    c.op = op;
    send_cmd(c);
  endtask

  // Stop sending, wait until every owed row is in, then let the queue settle.
  task automatic drain_rows();
    in_if.valid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_TEXT_LENGTH:   cur_len     = value;
      CFG_SCROLL_ENABLE: cur_enable  = value[0];
      CFG_GAP_COLUMNS:   cur_spacing = value[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // The first restart shows an all-blank frame. A tick while paused and a tick
  // with no text must both vanish without any rows.
  task automatic test_restart_and_paused();
    put_op(OP_RESTART);
    put_op(OP_TICK);
    drain_rows();
    write_reg(CFG_SCROLL_ENABLE, 7'd1);
    put_op(OP_TICK);
    drain_rows();
  endtask

  // Text entries at the edges of the printable range and well outside it, plus
  // font writes inside and past the font. The space glyph gets a pattern so that
  // unprintable codes, which fall back to it, are not simply blank.
  task automatic test_store_writes();
    put_text(0, TILDE_CODE);
    put_text(1, SPACE_CODE);
    put_text(2, SPACE_CODE - 8'd1);
    put_text(3, TILDE_CODE + 8'd1);
    put_text(4, 8'hFF);
    put_text(MAX_TEXT - 1, 8'h00);
    put_font(TILDE_CODE - SPACE_CODE, ROWS - 1, 5'h1F);
    put_font(FONT_ENTRIES, 0, 5'h1F);
    put_font(7'h7F, ROWS - 1, 5'h1F);
    put_font(0, 0, 5'h11);
  endtask

  // One character with the spacing register at zero, which must behave as one
  // blank column: glyph, gap, tail and the wrap back to the first column.
  task automatic test_single_glyph_wrap();
    drain_rows();
    write_reg(CFG_TEXT_LENGTH, 7'd1);
    write_reg(CFG_GAP_COLUMNS, 7'd0);
    repeat (2 * (GLYPH_COLUMNS + 1) + 1) put_op(OP_TICK);
    drain_rows();
    write_reg(CFG_SCROLL_ENABLE, 7'd0);
    put_op(OP_TICK);
    put_op(OP_RESTART);
  endtask

  // Fill the whole text store, then scroll a few characters with the largest
  // length the register takes, and then with exactly the store size and the
  // widest gap.
  task automatic test_long_text();
    drain_rows();
    for (int i = 0; i < MAX_TEXT; i++) put_text(i, 8'($urandom));
    drain_rows();
    write_reg(CFG_TEXT_LENGTH, 7'h7F);
    write_reg(CFG_SCROLL_ENABLE, 7'd1);
    write_reg(CFG_GAP_COLUMNS, 7'd0);
    put_op(OP_RESTART);
    repeat (20) put_op(OP_TICK);
    drain_rows();
    write_reg(CFG_TEXT_LENGTH, 7'(MAX_TEXT));
    write_reg(CFG_GAP_COLUMNS, 7'd7);
    repeat (10) put_op(OP_TICK);
  endtask

  // Mixed traffic in phases, each with its own register settings. Most phases
  // use short text so that full passes and wraps happen; a few use the
  // longest lengths, one runs paused, one has no text and one has no idling.
  task automatic test_random_mix();
    int len_pick;
    for (int p = 0; p < 8; p++) begin
      drain_rows();
      idle_on = (p != 2);
      if (p == 6) begin
        len_pick = 0;
      end else if ($urandom_range(0, 9) < 7) begin
        len_pick = $urandom_range(1, 6);
      end else begin
        len_pick = $urandom_range(MAX_TEXT - 2, 127);
      end
      write_reg(CFG_TEXT_LENGTH, 7'(len_pick));
      write_reg(CFG_SCROLL_ENABLE, (p == 5) ? 7'd0 : 7'd1);
      if (p == 0) begin
        write_reg(CFG_GAP_COLUMNS, 7'd7);
      end else if (p == 1) begin
        write_reg(CFG_GAP_COLUMNS, 7'd1);
      end else begin
        write_reg(CFG_GAP_COLUMNS, 7'($urandom_range(0, 7)));
      end
      repeat (10) send_cmd(random_cmd());
    end
    idle_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready is held low for a random number of cycles after each
  // accepted row, and each accepted row is checked against the oldest one owed.
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        rx_hold--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_rows.size() == 0) begin
        $display("%0t: row with none expected: row %0d bits %h last %0b", $time,
                 out_if.row_number, out_if.row_bits, out_if.last_row);
        fail_count++;
      end else begin
        head_row = pending_rows.pop_front();
        if (out_if.row_number !== head_row.row_number) begin
          $display("%0t: row_number expected %0d, actual %0d", $time,
                   head_row.row_number, out_if.row_number);
          fail_count++;
        end
        if (out_if.row_bits !== head_row.row_bits) begin
          $display("%0t: row_bits of row %0d expected %h, actual %h", $time,
                   head_row.row_number, head_row.row_bits, out_if.row_bits);
          fail_count++;
        end
        if (out_if.last_row !== head_row.last_row) begin
          $display("%0t: last_row of row %0d expected %0b, actual %0b", $time,
                   head_row.row_number, head_row.last_row, out_if.last_row);
          fail_count++;
        end
      end
      rx_hold = idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  // Watchdog: ends the run if no transaction moves on either channel for too
  // long, which would mean the block has hung.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_TEXT_LENGTH;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.operation   = OP_TEXT_WRITE;
    in_if.text_index  = '0;
    in_if.char_code   = '0;
    in_if.glyph_index = '0;
    in_if.glyph_row   = '0;
    in_if.glyph_bits  = '0;

    // Shadow state as the block comes out of reset.
    shadow_font = FONT_ROM;
    for (int r = 0; r < ROWS; r++) shadow_frame[r] = '0;
    for (int i = 0; i < MAX_TEXT; i++) begin
      shadow_text[i]  = '0;
      text_written[i] = 1'b0;
    end
    text_fill    = 0;
    seg          = SEG_GLYPH;
    char_pos     = 0;
    col_cnt      = 0;
    gap_cnt      = 0;
    tail_cnt     = 0;
    cur_len      = '0;
    cur_enable   = 1'b0;
    cur_spacing  = 3'd1;
    fail_count   = 0;
    idle_on      = 1'b1;
    rx_hold      = 0;
    quiet_cycles = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The first transaction is only taken once the font fill is done.
    test_restart_and_paused();
    test_store_writes();
    test_single_glyph_wrap();
    test_long_text();
    test_random_mix();

    drain_rows();
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
